[hw/rtl/gpal_pkg.sv]
// ----------------------------------------------------------------------------
// gpal_pkg
// Shared widths, register codes and the work record that moves down the
// divider chain of the gradient palette unit.
// ----------------------------------------------------------------------------
package gpal_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CNT_W       = 3;
	localparam int STOP_W      = 32;
	localparam int STOP_REGS   = 5;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_USED_STOPS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STOP_FIRST = 3'd1;

	// reset values
	localparam logic [CNT_W-1:0]  USED_STOPS_RESET = 3'd2;
	localparam logic [CNT_W-1:0]  USED_STOPS_MIN   = 3'd2;
	localparam logic [STOP_W-1:0] STOP_RESET_FIRST = 32'h0000_0000;
	localparam logic [STOP_W-1:0] STOP_RESET_REST  = 32'hFFFF_FFFF;

	// geometry
	localparam int DEFAULT_MAX_STOPS = 5;
	localparam int PALETTE_ENTRIES   = 256;
	localparam int INDEX_W           = 8;
	localparam int CHAN_W            = 8;
	localparam int RGB_W             = 3 * CHAN_W;
	localparam int QUOT_W            = 8;   // Q8 weight bits, one per divider cell
	localparam int COLOR_W           = 16;

	// work record carried from cell to cell
	typedef struct packed {
		logic [INDEX_W-1:0] rem;     // partial remainder, below span unless full or zero is set
		logic [INDEX_W-1:0] span;    // upper stop index minus lower stop index
		logic [QUOT_W-1:0]  quot;    // quotient bits gathered so far
		logic               full;    // weight saturates at one
		logic               zero;    // weight is zero
		logic [RGB_W-1:0]   lo_rgb;  // lower stop color
		logic [RGB_W-1:0]   hi_rgb;  // upper stop color
	} gpal_work_t;

endpackage

[hw/rtl/gradient_palette_rgb565_unit.sv]
// ----------------------------------------------------------------------------
// gradient_palette_rgb565_unit
// Multi-stop linear gradient lookup returning RGB565 colors.
// ----------------------------------------------------------------------------
// Takes one palette index per cycle unless stalled. An entry stage picks the
// segment, a chain of eight divider cells forms the Q8 weight one bit per
// cell, and an output stage blends and packs the color. Every stage moves
// forward on its own, so bubbles close up and new items are taken while a
// finished color waits at the output. The user must write stops and the stop
// count through the cfg port while no item is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module gradient_palette_rgb565_unit #(
	parameter int MAX_STOPS = gpal_pkg::DEFAULT_MAX_STOPS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gpal_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gpal_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [gpal_pkg::INDEX_W-1:0]      palette_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [gpal_pkg::COLOR_W-1:0]      color_565
);
	import gpal_pkg::*;

	logic [CNT_W-1:0]  used_stops_q;
	logic [STOP_W-1:0] stop_q [MAX_STOPS];

	logic       front_en;
	logic       front_valid;
	gpal_work_t front_work;
	logic       cell_en    [QUOT_W];
	logic       cell_valid [QUOT_W];
	gpal_work_t cell_work  [QUOT_W];
	logic       blend_en;

	// stop count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_stops_q <= USED_STOPS_RESET;
		end else if (cfg_we && (cfg_index == REG_USED_STOPS)) begin
			used_stops_q <= cfg_data[CNT_W-1:0];
		end
	end

	// stop registers; stops beyond the register set stay at their reset value
	for (genvar k = 0; k < MAX_STOPS; k++) begin : g_stop
		if (k < STOP_REGS) begin : g_reg
			localparam logic [STOP_W-1:0] RST = (k == 0) ? STOP_RESET_FIRST : STOP_RESET_REST;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stop_q[k] <= RST;
				end else if (cfg_we && (cfg_index == CFG_INDEX_W'(REG_STOP_FIRST + k))) begin
					stop_q[k] <= cfg_data[STOP_W-1:0];
				end
			end
		end else begin : g_const
			assign stop_q[k] = STOP_RESET_REST;
		end
	end

	gpal_front #(
		.MaxStops(MAX_STOPS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.palette_index(palette_index),
		.used_stops   (used_stops_q),
		.stops        (stop_q),
		.next_en      (cell_en[0]),
		.en           (front_en),
		.valid_s1     (front_valid),
		.work_s1      (front_work)
	);

	assign in_stall = !front_en;

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
		logic       prev_valid;
		gpal_work_t prev_work;
		logic       next_en;
		if (i == 0) begin : g_first
			assign prev_valid = front_valid;
			assign prev_work  = front_work;
		end else begin : g_mid
			assign prev_valid = cell_valid[i - 1];
			assign prev_work  = cell_work[i - 1];
		end
		if (i == QUOT_W - 1) begin : g_last
			assign next_en = blend_en;
		end else begin : g_inner
			assign next_en = cell_en[i + 1];
		end
		gpal_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_valid(prev_valid),
			.prev_work (prev_work),
			.next_en   (next_en),
			.en        (cell_en[i]),
			.valid_q   (cell_valid[i]),
			.work_q    (cell_work[i])
		);
	end

	gpal_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.prev_valid(cell_valid[QUOT_W - 1]),
		.prev_work (cell_work[QUOT_W - 1]),
		.out_stall (out_stall),
		.en        (blend_en),
		.out_valid (out_valid),
		.color_565 (color_565)
	);

endmodule

[hw/rtl/gpal_front.sv]
// ----------------------------------------------------------------------------
// gpal_front
// Entry stage: clamps the index and stop count, picks the gradient segment
// and loads the first divider operands.
// ----------------------------------------------------------------------------
module gpal_front #(
	parameter int MaxStops = gpal_pkg::DEFAULT_MAX_STOPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [gpal_pkg::INDEX_W-1:0]  palette_index,
	input  logic [gpal_pkg::CNT_W-1:0]    used_stops,
	input  logic [gpal_pkg::STOP_W-1:0]   stops [MaxStops],
	input  logic                          next_en,
	output logic                          en,
	output logic                          valid_s1,
	output gpal_pkg::gpal_work_t          work_s1
);
	import gpal_pkg::*;

	localparam int SEG_W = $clog2(MaxStops);

	logic [INDEX_W-1:0] idx_c;
	logic [CNT_W-1:0]   count_c;
	logic [SEG_W-1:0]   seg_c;
	logic [STOP_W-1:0]  lo_c;
	logic [STOP_W-1:0]  hi_c;
	logic [INDEX_W-1:0] lo_idx_c;
	logic [INDEX_W-1:0] hi_idx_c;
	logic [INDEX_W-1:0] dist_c;
	logic [INDEX_W-1:0] span_c;
	logic               zero_c;
	logic               full_c;
	gpal_work_t         work_c;

	// clamp index to the palette and count to the usable range
	always_comb begin
		if ({1'b0, palette_index} >= (INDEX_W + 1)'(PALETTE_ENTRIES)) begin
			idx_c = INDEX_W'(PALETTE_ENTRIES - 1);
		end else begin
			idx_c = palette_index;
		end
		if (used_stops < USED_STOPS_MIN) begin
			count_c = USED_STOPS_MIN;
		end else if (used_stops > CNT_W'(MaxStops)) begin
			count_c = CNT_W'(MaxStops);
		end else begin
			count_c = used_stops;
		end
	end

	// walk segments while the index lies above the upper stop
	always_comb begin
		logic go;
		go    = 1'b1;
		seg_c = '0;
		for (int s = 0; s < MaxStops - 2; s++) begin
			if (go && (CNT_W'(s + 2) < count_c) && (idx_c > stops[s + 1][31:24])) begin
				seg_c = SEG_W'(s + 1);
			end else begin
				go = 1'b0;
			end
		end
	end

	// select lower and upper stop of the chosen segment
	always_comb begin
		lo_c = stops[0];
		hi_c = stops[1];
		for (int s = 0; s < MaxStops - 1; s++) begin
			if (seg_c == SEG_W'(s)) begin
				lo_c = stops[s];
				hi_c = stops[s + 1];
			end
		end
	end

	// set up the weight division
	always_comb begin
		lo_idx_c = lo_c[31:24];
		hi_idx_c = hi_c[31:24];
		dist_c   = idx_c - lo_idx_c;
		span_c   = hi_idx_c - lo_idx_c;
		zero_c   = !((hi_idx_c > lo_idx_c) && (idx_c >= lo_idx_c));
		full_c   = !zero_c && (dist_c >= span_c);
		work_c.rem    = dist_c;
		work_c.span   = span_c;
		work_c.quot   = '0;
		work_c.full   = full_c;
		work_c.zero   = zero_c;
		work_c.lo_rgb = lo_c[RGB_W-1:0];
		work_c.hi_rgb = hi_c[RGB_W-1:0];
	end

	assign en = !valid_s1 || next_en;

	// hold valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// load operands
	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_c;
		end
	end

endmodule

[hw/rtl/gpal_div_cell.sv]
// ----------------------------------------------------------------------------
// gpal_div_cell
// One restoring division step: doubles the remainder, produces one quotient
// bit and hands the item to the next cell.
// ----------------------------------------------------------------------------
module gpal_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 prev_valid,
	input  gpal_pkg::gpal_work_t prev_work,
	input  logic                 next_en,
	output logic                 en,
	output logic                 valid_q,
	output gpal_pkg::gpal_work_t work_q
);
	import gpal_pkg::*;

	logic [INDEX_W:0] rem2_c;
	logic             ge_c;
	gpal_work_t       work_c;

	// shift, compare and subtract
	always_comb begin
		rem2_c = {prev_work.rem, 1'b0};
		ge_c   = rem2_c >= {1'b0, prev_work.span};
		work_c = prev_work;
		if (ge_c) begin
			work_c.rem = INDEX_W'(rem2_c - {1'b0, prev_work.span});
		end else begin
			work_c.rem = rem2_c[INDEX_W-1:0];
		end
		work_c.quot = {prev_work.quot[QUOT_W-2:0], ge_c};
	end

	assign en = !valid_q || next_en;

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= work_c;
		end
	end

endmodule

[hw/rtl/gpal_blend.sv]
// ----------------------------------------------------------------------------
// gpal_blend
// Output stage: mixes the two stop colors by the Q8 weight, clamps each
// channel and packs the result to RGB565 in the output register.
// ----------------------------------------------------------------------------
module gpal_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          prev_valid,
	input  gpal_pkg::gpal_work_t          prev_work,
	input  logic                          out_stall,
	output logic                          en,
	output logic                          out_valid,
	output logic [gpal_pkg::COLOR_W-1:0]  color_565
);
	import gpal_pkg::*;

	logic [QUOT_W:0]   t_c;
	logic [CHAN_W-1:0] r_c;
	logic [CHAN_W-1:0] g_c;
	logic [CHAN_W-1:0] b_c;

	// a + floor((b - a) * t / 256), clamped to the channel range
	function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input logic [QUOT_W:0] t);
		logic signed [CHAN_W:0]       delta;
		logic signed [CHAN_W+QUOT_W+2:0] prod;
		logic signed [CHAN_W+2:0]     v;
		delta = signed'({1'b0, b}) - signed'({1'b0, a});
		prod  = delta * signed'({1'b0, t});
		v     = signed'({3'b000, a}) + signed'(prod[CHAN_W+QUOT_W+2:QUOT_W]);
		if (v < 0) begin
			return '0;
		end else if (v > signed'((CHAN_W + 3)'(255))) begin
			return '1;
		end else begin
			return v[CHAN_W-1:0];
		end
	endfunction

	// pick the weight and mix each channel
	always_comb begin
		if (prev_work.full) begin
			t_c = (QUOT_W + 1)'(256);
		end else if (prev_work.zero) begin
			t_c = '0;
		end else begin
			t_c = {1'b0, prev_work.quot};
		end
		r_c = mix(prev_work.lo_rgb[23:16], prev_work.hi_rgb[23:16], t_c);
		g_c = mix(prev_work.lo_rgb[15:8], prev_work.hi_rgb[15:8], t_c);
		b_c = mix(prev_work.lo_rgb[7:0], prev_work.hi_rgb[7:0], t_c);
	end

	assign en = !out_valid || !out_stall;

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= prev_valid;
		end
	end

	// pack to 5:6:5
	always_ff @(posedge clk) begin
		if (en) begin
			color_565 <= {r_c[7:3], g_c[7:2], b_c[7:3]};
		end
	end

endmodule
